// ----- src/utf8nv_pkg.sv -----
package utf8nv_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 6;
  localparam int unsigned PendW  = 2;

  localparam logic [CountW-1:0] MaxRunesReset = 6'd12;
  localparam logic [CountW-1:0] CountSat      = 6'd63;
  localparam logic [CountW-1:0] MinRunes      = 6'd2;

  // lead and continuation byte masks and patterns
  localparam logic [ByteW-1:0] ContMask  = 8'hc0;
  localparam logic [ByteW-1:0] ContPat   = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'he0;
  localparam logic [ByteW-1:0] Lead2Pat  = 8'hc0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hf0;
  localparam logic [ByteW-1:0] Lead3Pat  = 8'he0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hf8;
  localparam logic [ByteW-1:0] Lead4Pat  = 8'hf0;
  localparam logic [ByteW-1:0] C1Lead    = 8'hc2;

  localparam logic [PendW-1:0] PendNone = 2'd0;
  localparam logic [PendW-1:0] PendOne  = 2'd1;
  localparam logic [PendW-1:0] PendTwo  = 2'd2;
  localparam logic [PendW-1:0] PendThree = 2'd3;

  typedef struct packed {
    logic [PendW-1:0]  pend;
    logic [CountW-1:0] count;
    logic              fault;
  } name_state_t;

  typedef struct packed {
    logic [ByteW-1:0] name_byte;
    logic             last_byte;
    logic             empty_name;
  } name_req_t;

  typedef struct packed {
    logic              name_ok;
    logic [CountW-1:0] char_count;
  } verdict_t;

endpackage

// ----- src/utf8nv_name_if.sv -----
interface utf8nv_name_if;
  logic                              valid;
  logic                              ready;
  logic [utf8nv_pkg::ByteW-1:0]      name_byte;
  logic                              last_byte;
  logic                              empty_name;

  modport source (output valid, name_byte, last_byte, empty_name, input ready);
  modport sink   (input valid, name_byte, last_byte, empty_name, output ready);
endinterface

// ----- src/utf8nv_verdict_if.sv -----
interface utf8nv_verdict_if;
  logic                              valid;
  logic                              ready;
  logic                              name_ok;
  logic [utf8nv_pkg::CountW-1:0]     char_count;

  modport source (output valid, name_ok, char_count, input ready);
  modport sink   (input valid, name_ok, char_count, output ready);
endinterface

// ----- src/utf8nv_cfg_if.sv -----
interface utf8nv_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [utf8nv_pkg::CountW-1:0]     max_runes;

  modport source (output valid, max_runes, input ready);
  modport sink   (input valid, max_runes, output ready);
endinterface

// ----- src/utf8_name_letter_validator_top.sv -----
// The request carrying the last byte is held in the input register; its verdict then lands in the output register.
// Throughput: one byte per cycle; the input register feeds the decode logic, whose
// verdict lands in the output register, so a byte is taken while a verdict waits.
// The input stalls only while the output register holds a verdict not yet taken.
// Reset (rst_ni low, async): pipeline empty, name state cleared, max_runes back to 12.
module utf8_name_letter_validator_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  utf8nv_cfg_if.sink       cfg,
  utf8nv_name_if.sink      name_in,
  utf8nv_verdict_if.source verdict_out
);

  logic [utf8nv_pkg::CountW-1:0] max_runes_q;

  logic                    s1_valid_q;
  utf8nv_pkg::name_req_t   s1_req_q;
  utf8nv_pkg::name_state_t state_q;

  logic                    out_valid_q;
  utf8nv_pkg::verdict_t    out_q;

  utf8nv_pkg::name_state_t state_d;
  utf8nv_pkg::verdict_t    verdict_d;
  logic                    done;
  logic                    out_free;
  logic                    s1_adv;
  logic                    in_fire;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_runes_q <= utf8nv_pkg::MaxRunesReset;
    end else if (cfg.valid) begin
      max_runes_q <= cfg.max_runes;
    end
  end

  utf8nv_decode u_decode (
    .state_i     (state_q),
    .req_i       (s1_req_q),
    .max_runes_i (max_runes_q),
    .state_o     (state_d),
    .done_o      (done),
    .verdict_o   (verdict_d)
  );

  assign out_free      = !out_valid_q || verdict_out.ready;
  // stage 1 moves on unless it has a verdict and the output is still occupied
  assign s1_adv        = s1_valid_q && (!done || out_free);
  assign name_in.ready = !s1_valid_q || s1_adv;
  assign in_fire       = name_in.valid && name_in.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (name_in.ready) begin
        s1_valid_q <= name_in.valid;
      end
      if (s1_adv) begin
        state_q <= state_d;
      end
      if (s1_adv && done) begin
        out_valid_q <= 1'b1;
      end else if (verdict_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q.name_byte  <= name_in.name_byte;
      s1_req_q.last_byte  <= name_in.last_byte;
      s1_req_q.empty_name <= name_in.empty_name;
    end
    if (s1_adv && done) begin
      out_q <= verdict_d;
    end
  end

  assign verdict_out.valid      = out_valid_q;
  assign verdict_out.name_ok    = out_q.name_ok;
  assign verdict_out.char_count = out_q.char_count;

  a_state_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && done |=> state_q == '0)
    else $error("name state not cleared after verdict");

  a_pass_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.name_ok |->
      out_q.char_count == '0 || out_q.char_count >= utf8nv_pkg::MinRunes)
    else $error("pass verdict with count below minimum");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !name_in.ready |-> out_valid_q && !verdict_out.ready && s1_valid_q)
    else $error("input stalled without a blocked verdict");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !verdict_out.ready |=> out_valid_q)
    else $error("pending verdict dropped");

endmodule

// ----- src/utf8nv_decode.sv -----
module utf8nv_decode (
  input  utf8nv_pkg::name_state_t             state_i,
  input  utf8nv_pkg::name_req_t               req_i,
  input  logic [utf8nv_pkg::CountW-1:0]       max_runes_i,
  output utf8nv_pkg::name_state_t             state_o,
  output logic                                done_o,
  output utf8nv_pkg::verdict_t                verdict_o
);

  utf8nv_pkg::name_state_t nxt;
  logic [utf8nv_pkg::ByteW-1:0] b;
  logic counted;
  logic fault_end;

  assign b = req_i.name_byte;

  always_comb begin
    nxt     = state_i;
    counted = 1'b0;
    if (state_i.pend != utf8nv_pkg::PendNone) begin
      if ((b & utf8nv_pkg::ContMask) == utf8nv_pkg::ContPat) begin
        nxt.pend = state_i.pend - utf8nv_pkg::PendOne;
      end else begin
        nxt.fault = 1'b1;
        nxt.pend  = utf8nv_pkg::PendNone;
      end
    end else if (!b[utf8nv_pkg::ByteW-1]) begin
      if (!(b inside {[8'h61:8'h7a], [8'h41:8'h5a]})) begin
        nxt.fault = 1'b1;
      end
      counted = 1'b1;
    end else if ((b & utf8nv_pkg::Lead2Mask) == utf8nv_pkg::Lead2Pat) begin
      nxt.pend = utf8nv_pkg::PendOne;
      if (b == utf8nv_pkg::C1Lead) begin
        nxt.fault = 1'b1;
      end
      counted = 1'b1;
    end else if ((b & utf8nv_pkg::Lead3Mask) == utf8nv_pkg::Lead3Pat) begin
      nxt.pend = utf8nv_pkg::PendTwo;
      counted  = 1'b1;
    end else if ((b & utf8nv_pkg::Lead4Mask) == utf8nv_pkg::Lead4Pat) begin
      nxt.pend = utf8nv_pkg::PendThree;
      counted  = 1'b1;
    end else begin
      // stray continuation, 5+ byte lead or 0xfe/0xff byte
      nxt.fault = 1'b1;
    end
    if (counted && (state_i.count != utf8nv_pkg::CountSat)) begin
      nxt.count = state_i.count + 1'b1;
    end
  end

  // a sequence cut off by the end of the name fails
  assign fault_end = nxt.fault || (nxt.pend != utf8nv_pkg::PendNone);

  always_comb begin
    done_o    = req_i.empty_name || req_i.last_byte;
    state_o   = nxt;
    verdict_o.name_ok    = !fault_end && (nxt.count >= utf8nv_pkg::MinRunes)
                           && (nxt.count <= max_runes_i);
    verdict_o.char_count = nxt.count;
    if (req_i.empty_name) begin
      verdict_o.name_ok    = 1'b1;
      verdict_o.char_count = '0;
    end
    if (done_o) begin
      state_o = '0;
    end
  end

endmodule
